// ===== sv/u8l1_pkg.sv =====
// ----------------------------------------------------------------------------
// u8l1_pkg
// Shared types and constants for the UTF-8 to Latin-1 transcoder.
// ----------------------------------------------------------------------------
package u8l1_pkg;

  // Widths of the decode state
  localparam int unsigned CodeW    = 21;
  localparam int unsigned PendingW = 2;

  // Lead byte patterns and masks
  localparam logic [7:0] Lead2Mask = 8'hE0;
  localparam logic [7:0] Lead2Pat  = 8'hC0;
  localparam logic [7:0] Lead3Mask = 8'hF0;
  localparam logic [7:0] Lead3Pat  = 8'hE0;
  localparam logic [7:0] Lead4Mask = 8'hF8;
  localparam logic [7:0] Lead4Pat  = 8'hF0;

  // Sequence lengths as continuation counts
  localparam logic [PendingW-1:0] PendNone = 2'd0;
  localparam logic [PendingW-1:0] PendOne  = 2'd1;
  localparam logic [PendingW-1:0] PendTwo  = 2'd2;
  localparam logic [PendingW-1:0] PendThree = 2'd3;

  // Special characters
  localparam logic [CodeW-1:0] RightQuoteCp = 21'h002019;
  localparam logic [7:0]       Apostrophe   = 8'h27;
  localparam logic [7:0]       Terminator   = 8'h00;
  localparam logic [7:0]       ReplReset    = 8'h3F;

  // Result of decoding one word against the current state
  typedef struct packed {
    logic                emit;
    logic [7:0]          out_byte;
    logic                end_of_text;
    logic [CodeW-1:0]    code_nxt;
    logic [PendingW-1:0] pending_nxt;
  } dec_t;

endpackage

// ===== sv/u8l1_ifs.sv =====
// ----------------------------------------------------------------------------
// u8l1 channel interfaces
// Valid/ready channels for the input byte stream and the result stream.
// ----------------------------------------------------------------------------
interface u8l1_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface u8l1_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       end_of_text;

  modport source (output valid, output out_byte, output end_of_text, input ready);
  modport sink   (input valid, input out_byte, input end_of_text, output ready);
endinterface

// ===== sv/u8l1_decode.sv =====
// ----------------------------------------------------------------------------
// u8l1_decode
// Single-pass decode of one UTF-8 byte against the gathered code point and
// the count of continuation bytes still expected.
// ----------------------------------------------------------------------------
module u8l1_decode (
  input  logic [7:0]                     in_byte,
  input  logic [u8l1_pkg::CodeW-1:0]     code,
  input  logic [u8l1_pkg::PendingW-1:0]  pending,
  input  logic [7:0]                     repl_char,
  output u8l1_pkg::dec_t                 dec
);

  logic [u8l1_pkg::CodeW-1:0]    cp;
  logic [u8l1_pkg::CodeW-1:0]    cont_code;
  logic [u8l1_pkg::PendingW-1:0] cont_pending;
  logic [7:0]                    latin;

  // Append the low six bits of a continuation word
  assign cont_code    = {code[u8l1_pkg::CodeW-7:0], in_byte[5:0]};
  assign cont_pending = pending - u8l1_pkg::PendOne;

  // Code point to map: a finished sequence or a single word
  assign cp = (pending != u8l1_pkg::PendNone) ? cont_code
                                              : {14'd0, in_byte[6:0]};

  // Map the code point onto Latin-1
  always_comb begin
    priority if (cp[u8l1_pkg::CodeW-1:8] == '0) begin
      latin = cp[7:0];
    end else if (cp == u8l1_pkg::RightQuoteCp) begin
      latin = u8l1_pkg::Apostrophe;
    end else begin
      latin = repl_char;
    end
  end

  // Pick the next state and result
  always_comb begin
    dec.emit        = 1'b1;
    dec.out_byte    = latin;
    dec.end_of_text = 1'b0;
    dec.code_nxt    = '0;
    dec.pending_nxt = u8l1_pkg::PendNone;
    priority if (in_byte == u8l1_pkg::Terminator) begin
      // drop any partial sequence and close the text
      dec.out_byte    = u8l1_pkg::Terminator;
      dec.end_of_text = 1'b1;
    end else if (pending != u8l1_pkg::PendNone) begin
      dec.pending_nxt = cont_pending;
      if (cont_pending != u8l1_pkg::PendNone) begin
        dec.emit     = 1'b0;
        dec.code_nxt = cont_code;
      end
    end else if ((in_byte & u8l1_pkg::Lead2Mask) == u8l1_pkg::Lead2Pat) begin
      dec.emit        = 1'b0;
      dec.code_nxt    = {16'd0, in_byte[4:0]};
      dec.pending_nxt = u8l1_pkg::PendOne;
    end else if ((in_byte & u8l1_pkg::Lead3Mask) == u8l1_pkg::Lead3Pat) begin
      dec.emit        = 1'b0;
      dec.code_nxt    = {17'd0, in_byte[3:0]};
      dec.pending_nxt = u8l1_pkg::PendTwo;
    end else if ((in_byte & u8l1_pkg::Lead4Mask) == u8l1_pkg::Lead4Pat) begin
      dec.emit        = 1'b0;
      dec.code_nxt    = {18'd0, in_byte[2:0]};
      dec.pending_nxt = u8l1_pkg::PendThree;
    end else begin
      // stray or plain word stands alone as its low seven bits
      dec.emit = 1'b1;
    end
  end

endmodule

// ===== sv/utf8_to_latin1_transcoder.sv =====
// ----------------------------------------------------------------------------
// utf8_to_latin1_transcoder
// Turns a UTF-8 byte stream into Latin-1 words, one result per character.
// ----------------------------------------------------------------------------
// Result words are registered in the output register, or in its skid entry.
// Throughput: one input word per cycle while the skid entry is empty; the
//   per-word decode and the state update close together, and a two-entry
//   output buffer keeps the input open through an output stall until it fills.
// Reset (rst_n low, synchronous): clears the partial code point, the pending
//   count and the output buffer; replacement character returns to '?'.
module utf8_to_latin1_transcoder (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata,
  u8l1_in_if.sink           in_ch,
  u8l1_out_if.source        out_ch
);

  logic [u8l1_pkg::CodeW-1:0]    code_r;
  logic [u8l1_pkg::PendingW-1:0] pending_r;
  logic [7:0]                    repl_r;
  logic                          out_valid_r;
  logic [7:0]                    out_byte_r;
  logic                          out_eot_r;
  logic                          skid_valid_r;
  logic [7:0]                    skid_byte_r;
  logic                          skid_eot_r;
  u8l1_pkg::dec_t                dec;
  logic                          accept;
  logic                          push;
  logic                          pop;

  assign in_ch.ready = ~skid_valid_r;
  assign accept      = in_ch.valid & in_ch.ready;
  assign push        = accept & dec.emit;
  assign pop         = out_valid_r & out_ch.ready;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.end_of_text = out_eot_r;

  u8l1_decode u_decode (
    .in_byte   (in_ch.in_byte),
    .code      (code_r),
    .pending   (pending_r),
    .repl_char (repl_r),
    .dec       (dec)
  );

  // Replacement character register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repl_r <= u8l1_pkg::ReplReset;
    end else if (cfg_we) begin
      repl_r <= cfg_wdata;
    end
  end

  // Advance the decode state on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_r    <= '0;
      pending_r <= u8l1_pkg::PendNone;
    end else if (accept) begin
      code_r    <= dec.code_nxt;
      pending_r <= dec.pending_nxt;
    end
  end

  // Output register with a skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload of the output buffer
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_byte_r <= skid_byte_r;
        out_eot_r  <= skid_eot_r;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_byte_r <= dec.out_byte;
        out_eot_r  <= dec.end_of_text;
      end else begin
        skid_byte_r <= dec.out_byte;
        skid_eot_r  <= dec.end_of_text;
      end
    end
  end

  // Skid entry is only ever filled behind a full output register
  a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid with empty output register");

  // A zero word always leaves the decoder with nothing pending
  a_zero_clears : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.in_byte == u8l1_pkg::Terminator) |=>
      (pending_r == u8l1_pkg::PendNone && code_r == '0))
    else $error("terminator did not clear decode state");

  // The terminator word carries a zero byte
  a_eot_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_eot_r) |-> (out_byte_r == u8l1_pkg::Terminator))
    else $error("end of text with nonzero byte");

  // Mid-sequence words count down without emitting
  a_countdown : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.in_byte != u8l1_pkg::Terminator &&
     (pending_r == u8l1_pkg::PendTwo || pending_r == u8l1_pkg::PendThree)) |->
      (!dec.emit && dec.pending_nxt == pending_r - u8l1_pkg::PendOne))
    else $error("continuation count out of step");

endmodule

// ===== dv/utf8_to_latin1_transcoder_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_to_latin1_transcoder_checker
// Passive checker for the transcoder. It follows every accepted input word
// with its own decoder state and replacement register, and queues the Latin-1
// word that each completed character should produce. Each accepted result
// word is compared field by field with the oldest queued word.
// ----------------------------------------------------------------------------
module utf8_to_latin1_transcoder_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  u8l1_in_if          in_ch,
  u8l1_out_if         out_ch,
  output int unsigned fail_count,
  output int unsigned pending_words
);

  typedef struct packed {
    logic [7:0] latin1;
    logic       eot;
  } latin1_word_t;

  typedef struct packed {
    logic                          emit;
    latin1_word_t                  word;
    logic [u8l1_pkg::CodeW-1:0]    code;
    logic [u8l1_pkg::PendingW-1:0] pend;
  } decode_step_t;

  logic [7:0]                    repl_char;
  logic [u8l1_pkg::CodeW-1:0]    code_acc;
  logic [u8l1_pkg::PendingW-1:0] cont_left;
  latin1_word_t                  latin1_expected[$];

  // Map a finished code point onto one Latin-1 byte
  function automatic logic [7:0] to_latin1_byte(logic [u8l1_pkg::CodeW-1:0] cp,
                                                logic [7:0] repl);
    if (cp < 256) return cp[7:0];
    if (cp == u8l1_pkg::RightQuoteCp) return u8l1_pkg::Apostrophe;
    return repl;
  endfunction

  // Advance the decoder by one UTF-8 byte
  function automatic decode_step_t decode_utf8_byte(logic [7:0] b,
                                                    logic [u8l1_pkg::CodeW-1:0] code,
                                                    logic [u8l1_pkg::PendingW-1:0] pend,
                                                    logic [7:0] repl);
    decode_step_t st;
    logic [u8l1_pkg::CodeW-1:0] acc;
    st = '0;
    st.code = code;
    st.pend = pend;
    if (b == 8'h00) begin
      // Terminator drops any partial character
      st.emit = 1'b1;
      st.word = '{latin1: u8l1_pkg::Terminator, eot: 1'b1};
      st.code = '0;
      st.pend = u8l1_pkg::PendNone;
    end else if (pend != u8l1_pkg::PendNone) begin
      // Any byte counts as a continuation here, only its low 6 bits matter
      acc = {code[u8l1_pkg::CodeW-7:0], b[5:0]};
      st.pend = pend - u8l1_pkg::PendOne;
      if (st.pend == u8l1_pkg::PendNone) begin
        st.emit = 1'b1;
        st.word = '{latin1: to_latin1_byte(acc, repl), eot: 1'b0};
        st.code = '0;
      end else begin
        st.code = acc;
      end
    end else if ((b & u8l1_pkg::Lead2Mask) == u8l1_pkg::Lead2Pat) begin
      st.code = u8l1_pkg::CodeW'(b[4:0]);
      st.pend = u8l1_pkg::PendOne;
    end else if ((b & u8l1_pkg::Lead3Mask) == u8l1_pkg::Lead3Pat) begin
      st.code = u8l1_pkg::CodeW'(b[3:0]);
      st.pend = u8l1_pkg::PendTwo;
    end else if ((b & u8l1_pkg::Lead4Mask) == u8l1_pkg::Lead4Pat) begin
      st.code = u8l1_pkg::CodeW'(b[2:0]);
      st.pend = u8l1_pkg::PendThree;
    end else begin
      // Stray continuation, 0xF8..0xFF or plain ASCII stands alone
      st.emit = 1'b1;
      st.word = '{latin1: to_latin1_byte(u8l1_pkg::CodeW'(b[6:0]), repl), eot: 1'b0};
    end
    return st;
  endfunction

  always @(posedge clk) begin
    decode_step_t st;
    latin1_word_t want;
    int unsigned  errs;
    errs = 0;
    if (!rst_n) begin
      repl_char = u8l1_pkg::ReplReset;
      code_acc  = '0;
      cont_left = u8l1_pkg::PendNone;
      latin1_expected.delete();
      fail_count    <= 0;
      pending_words <= 0;
    end else begin
      // Check the result word taken at this edge
      if (out_ch.valid && out_ch.ready) begin
        if (latin1_expected.size() == 0) begin
          $error("result word with nothing expected: out_byte %02h end_of_text %0b",
                 out_ch.out_byte, out_ch.end_of_text);
          errs++;
        end else begin
          want = latin1_expected.pop_front();
          if (out_ch.out_byte !== want.latin1) begin
            $error("out_byte: expected %02h, actual %02h", want.latin1, out_ch.out_byte);
            errs++;
          end
          if (out_ch.end_of_text !== want.eot) begin
            $error("end_of_text: expected %0b, actual %0b", want.eot, out_ch.end_of_text);
            errs++;
          end
        end
      end
      // Predict from the input word taken at this edge
      if (in_ch.valid && in_ch.ready) begin
        st = decode_utf8_byte(in_ch.in_byte, code_acc, cont_left, repl_char);
        code_acc  = st.code;
        cont_left = st.pend;
        if (st.emit) latin1_expected.push_back(st.word);
      end
      if (cfg_we) repl_char = cfg_wdata;
      fail_count    <= fail_count + errs;
      pending_words <= latin1_expected.size();
    end
  end

endmodule

// ===== dv/utf8_to_latin1_transcoder_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_to_latin1_transcoder_tb
// Drives UTF-8 text into the transcoder: a directed run over the lead byte
// kinds, stray bytes, the right quote, overlong and cut-off characters, then
// mostly well-formed random text under several replacement settings, with
// random idling on both channels, one quiet stretch and one long output stall.
// ----------------------------------------------------------------------------
module utf8_to_latin1_transcoder_tb;

  localparam int unsigned ClkPeriod = 20;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [7:0]  cfg_wdata;
  logic        quiet;
  logic        hold_req;
  int unsigned n_sent;
  int unsigned fail_count;
  int unsigned pending_words;

  u8l1_in_if  in_ch();
  u8l1_out_if out_ch();

  utf8_to_latin1_transcoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  utf8_to_latin1_transcoder_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .pending_words (pending_words)
  );

  // Extremes, every sequence length, right quote, stray and broken characters
  logic [7:0] directed_text [25] = '{
    8'h41, 8'h7F, 8'h80, 8'hFF, 8'hF8,
    8'hC3, 8'hA9,
    8'hE2, 8'h80, 8'h99,
    8'hF4, 8'h8F, 8'hBF, 8'hBF,
    8'hF7, 8'hBF, 8'hBF, 8'hBF,
    8'hC0, 8'h80,
    8'hE2, 8'h00,
    8'hC3, 8'hC3,
    8'h00
  };

  initial begin
    clk = 1'b0;
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  // Offer one word, with random idle cycles ahead of it, and hold until taken
  task automatic send_word(input logic [7:0] b);
    while (!quiet && $urandom_range(99) < 9) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    n_sent++;
  endtask

  // Continuation byte, now and then with arbitrary top bits
  function automatic logic [7:0] cont_byte();
    if ($urandom_range(9) == 0) return 8'($urandom_range(255));
    return 8'h80 | 8'($urandom_range(63));
  endfunction

  // Drop valid and wait until every expected word has come out
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // One random character: mostly well formed, some stray and cut-off bytes
  task automatic send_random_char();
    int unsigned kind;
    kind = $urandom_range(99);
    if (kind < 30) begin
      send_word(8'($urandom_range(1, 127)));
    end else if (kind < 50) begin
      send_word(8'hC0 | 8'($urandom_range(31)));
      send_word(cont_byte());
    end else if (kind < 65) begin
      if ($urandom_range(4) == 0) begin
        send_word(8'hE2);
        send_word(8'h80);
        send_word(8'h99);
      end else begin
        send_word(8'hE0 | 8'($urandom_range(15)));
        send_word(cont_byte());
        send_word(cont_byte());
      end
    end else if (kind < 75) begin
      send_word(8'hF0 | 8'($urandom_range(7)));
      repeat (3) send_word(cont_byte());
    end else if (kind < 80) begin
      send_word(8'h00);
    end else if (kind < 88) begin
      if ($urandom_range(1) == 0) send_word(8'h80 | 8'($urandom_range(63)));
      else send_word(8'hF8 | 8'($urandom_range(7)));
    end else if (kind < 94) begin
      // Cut off by the terminator
      send_word(8'hE0 | 8'($urandom_range(31)));
      if ($urandom_range(1) == 0) send_word(cont_byte() | 8'h01);
      send_word(8'h00);
    end else begin
      send_word(8'($urandom_range(255)));
    end
  endtask

  // Set the replacement character while idle, then run random text
  task automatic run_random_phase(input logic [7:0] repl, input int unsigned target,
                                  input bit no_idle, input bit long_hold);
    int unsigned hold_at;
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= repl;
    @(posedge clk);
    cfg_we <= 1'b0;
    quiet  <= no_idle;
    hold_at = n_sent + 30;
    while (n_sent < target) begin
      if (long_hold && n_sent >= hold_at) begin
        hold_req  <= 1'b1;
        long_hold = 1'b0;
      end
      send_random_char();
    end
    quiet <= 1'b0;
  endtask

  // Stimulus
  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = 8'h00;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = 8'h00;
    quiet         = 1'b0;
    hold_req      = 1'b0;
    n_sent        = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_text[i]) send_word(directed_text[i]);
    run_random_phase(8'hFF, 160, 1'b0, 1'b1);
    run_random_phase(8'h00, 295, 1'b1, 1'b0);
    run_random_phase(8'($urandom_range(1, 254)), 430, 1'b0, 1'b0);
    settle();

    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  // Result side: random idling plus one long stall on request
  initial begin
    int unsigned hold_left;
    bit          hold_done;
    hold_left    = 0;
    hold_done    = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_left = 300;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (!quiet && $urandom_range(99) < 9) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog
  initial begin
    #(ClkPeriod * 200000);
    $display("status: fail");
    $finish;
  end

endmodule
